### hw/rtl/tfhe_pkg.sv
// ----------------------------------------------------------------------------
// tfhe_pkg: shared types and constants of the TCP frame header extractor
// Holds the command entry passed from the front to the back, the result
// item, status codes and the header offsets used by the parser.
// ----------------------------------------------------------------------------
package tfhe_pkg;

	// Bytes at or beyond this position of a frame are ignored.
	localparam int MAX_FRAME_BYTES = 65536;
	// Position counter holds MAX_FRAME_BYTES itself once a frame runs long.
	localparam int POS_W = $clog2(MAX_FRAME_BYTES) + 1;
	// Width for payload window compares (position plus a full 16-bit length).
	localparam int CMP_W = (POS_W > 17 ? POS_W : 17) + 1;

	localparam int ETH_HEAD_BYTES = 14;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	localparam logic [51:0] MICROS_PER_SEC = 52'd1000000;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0] LINK_RAW_IP = 8'h02;
	localparam logic [7:0] PROTO_TCP = 8'h06;

	// Start of the IPv4 header within the frame.
	localparam logic [3:0] IP_START_NONE = 4'd0;
	localparam logic [3:0] IP_START_RAW = 4'd4;
	localparam logic [3:0] IP_START_ETH = 4'd14;

	// Byte offsets inside the IPv4 header.
	localparam logic [4:0] IP_OFS_IHL = 5'd0;
	localparam logic [4:0] IP_OFS_LEN = 5'd2;
	localparam logic [4:0] IP_OFS_PROTO = 5'd9;
	localparam logic [4:0] IP_OFS_SRC = 5'd12;
	localparam logic [4:0] IP_OFS_DST = 5'd16;

	// Byte offsets inside the TCP header.
	localparam logic [3:0] TCP_OFS_SPORT = 4'd0;
	localparam logic [3:0] TCP_OFS_DPORT = 4'd2;
	localparam logic [3:0] TCP_OFS_SEQ = 4'd4;
	localparam logic [3:0] TCP_OFS_ACK = 4'd8;
	localparam logic [3:0] TCP_OFS_DOFF = 4'd12;

	// Frame status codes.
	localparam logic [1:0] ST_TCP_DATA = 2'd0;
	localparam logic [1:0] ST_TCP_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOT_IPV4 = 2'd2;
	localparam logic [1:0] ST_NOT_TCP = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic [POS_W-1:0] pos;
		logic live;
		logic last;
		logic decide;
		logic [3:0] ip_start;
		logic [51:0] stamp;
	} cmd_t;

	typedef struct packed {
		logic [7:0] payload_value;
		logic is_summary;
		logic [1:0] frame_status;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] sequence_number;
		logic [31:0] acknowledge_number;
		logic [15:0] payload_length;
		logic [51:0] stamp_total_micros;
	} res_t;

endpackage

### hw/rtl/tfhe_front.sv
// ----------------------------------------------------------------------------
// tfhe_front: byte intake and frame classification
// Counts byte positions, samples the capture time, and decides the IPv4
// header start from the link bytes. Each byte becomes one command entry.
// ----------------------------------------------------------------------------
module tfhe_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] frame_byte,
	input logic frame_end,
	input logic [31:0] stamp_seconds,
	input logic [19:0] stamp_micros,
	output logic cmd_wr,
	output tfhe_pkg::cmd_t cmd,
	input logic cmd_full
);

	logic [tfhe_pkg::POS_W-1:0] pos_q;
	logic [7:0] hb0_q;
	logic [7:0] hb12_q;
	logic [51:0] stamp_q;

	logic accept;
	logic live;
	logic first;
	logic [51:0] stamp_now;
	logic [7:0] hb0_eff;
	logic [7:0] hb12_eff;
	logic [7:0] hb13_eff;
	logic [15:0] eth_type;
	logic [3:0] cls;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign cmd_wr = accept;

	assign live = pos_q < tfhe_pkg::POS_W'(tfhe_pkg::MAX_FRAME_BYTES);
	assign first = pos_q == '0;

	assign stamp_now = first
		? 52'(stamp_seconds) * tfhe_pkg::MICROS_PER_SEC + 52'(stamp_micros)
		: stamp_q;

	// Link bytes that have not arrived yet read as zero.
	assign hb0_eff = first ? frame_byte : hb0_q;
	assign hb12_eff = (pos_q == tfhe_pkg::POS_W'(12)) ? frame_byte
		: ((pos_q == tfhe_pkg::POS_W'(13)) ? hb12_q : 8'h00);
	assign hb13_eff = (pos_q == tfhe_pkg::POS_W'(13)) ? frame_byte : 8'h00;
	assign eth_type = {hb12_eff, hb13_eff};

	always_comb begin
		if (eth_type == tfhe_pkg::ETHERTYPE_IPV4) begin
			cls = tfhe_pkg::IP_START_ETH;
		end else if (hb0_eff == tfhe_pkg::LINK_RAW_IP) begin
			cls = tfhe_pkg::IP_START_RAW;
		end else begin
			cls = tfhe_pkg::IP_START_NONE;
		end
	end

	always_comb begin
		cmd.data = frame_byte;
		cmd.pos = pos_q;
		cmd.live = live;
		cmd.last = frame_end;
		// Classification happens on the last link byte, or earlier if the frame ends.
		cmd.decide = live && ((pos_q == tfhe_pkg::POS_W'(tfhe_pkg::ETH_HEAD_BYTES - 1))
			|| (frame_end && pos_q < tfhe_pkg::POS_W'(tfhe_pkg::ETH_HEAD_BYTES - 1)));
		cmd.ip_start = cls;
		cmd.stamp = stamp_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q <= '0;
			end else if (live) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (first) begin
				hb0_q <= frame_byte;
				stamp_q <= stamp_now;
			end
			if (pos_q == tfhe_pkg::POS_W'(12)) begin
				hb12_q <= frame_byte;
			end
		end
	end

endmodule

### hw/rtl/tfhe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tfhe_cmd_fifo: command queue between the front and the back
// A small register queue that lets the intake and the parser stall apart.
// ----------------------------------------------------------------------------
module tfhe_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input tfhe_pkg::cmd_t wr_data,
	output logic full,
	input logic rd_en,
	output tfhe_pkg::cmd_t rd_data,
	output logic empty
);

	localparam int PTR_W = $clog2(tfhe_pkg::CMD_DEPTH);
	localparam int CNT_W = $clog2(tfhe_pkg::CMD_DEPTH + 1);

	tfhe_pkg::cmd_t mem_q [tfhe_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = count_q == CNT_W'(tfhe_pkg::CMD_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hw/rtl/tfhe_back.sv
// ----------------------------------------------------------------------------
// tfhe_back: header field capture and result generation
// Stage one folds each byte into the frame's header registers; stage two
// decides whether the byte is TCP payload and builds the frame summary.
// ----------------------------------------------------------------------------
module tfhe_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_empty,
	input tfhe_pkg::cmd_t cmd,
	output logic cmd_rd,
	input logic res_full,
	output logic res_wr,
	output tfhe_pkg::res_t res
);

	typedef struct packed {
		logic [3:0] ip_start;
		logic [5:0] ihb;
		logic [5:0] thb;
		logic [15:0] tot;
		logic [7:0] proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] seq;
		logic [31:0] ack;
	} frame_t;

	localparam int PW = tfhe_pkg::POS_W;
	localparam int CW = tfhe_pkg::CMP_W;

	frame_t fr_q;
	frame_t cur;
	frame_t nx;
	tfhe_pkg::cmd_t ent_s1;
	logic vld_s1;
	logic half_q;

	logic [3:0] base;
	logic active;
	logic [PW-1:0] r;
	logic [PW-1:0] t;
	logic r_near;
	logic t_ok;

	logic [16:0] diff;
	logic [15:0] len;
	logic [CW-1:0] ipx;
	logic [CW-1:0] ihx;
	logic [CW-1:0] thx;
	logic [CW-1:0] off;
	logic [CW-1:0] pc;
	logic tcp;
	logic pay_hit;
	logic need_pay;
	logic need_sum;
	logic b_done;
	logic advance;
	tfhe_pkg::res_t res_pay;
	tfhe_pkg::res_t res_sum;

	// ---- stage one: header capture ----
	// Before the link header is classified, bytes are captured as if the IPv4
	// header began at byte four; the decision then keeps or drops that work.
	always_comb begin
		cur = (cmd.pos == '0) ? '0 : fr_q;
		base = (cmd.pos < PW'(tfhe_pkg::ETH_HEAD_BYTES)) ? tfhe_pkg::IP_START_RAW
			: cur.ip_start;
		active = cmd.live && (cmd.pos >= PW'(tfhe_pkg::IP_START_RAW))
			&& ((cmd.pos < PW'(tfhe_pkg::ETH_HEAD_BYTES))
			|| (cur.ip_start != tfhe_pkg::IP_START_NONE));
		r = cmd.pos - PW'(base);
		r_near = r < PW'(32);
		nx = cur;
		if (active && r_near) begin
			case (r[4:0])
				tfhe_pkg::IP_OFS_IHL: nx.ihb = {cmd.data[3:0], 2'b00};
				tfhe_pkg::IP_OFS_LEN: nx.tot[15:8] = cmd.data;
				tfhe_pkg::IP_OFS_LEN + 5'd1: nx.tot[7:0] = cmd.data;
				tfhe_pkg::IP_OFS_PROTO: nx.proto = cmd.data;
				tfhe_pkg::IP_OFS_SRC: nx.src[31:24] = cmd.data;
				tfhe_pkg::IP_OFS_SRC + 5'd1: nx.src[23:16] = cmd.data;
				tfhe_pkg::IP_OFS_SRC + 5'd2: nx.src[15:8] = cmd.data;
				tfhe_pkg::IP_OFS_SRC + 5'd3: nx.src[7:0] = cmd.data;
				tfhe_pkg::IP_OFS_DST: nx.dst[31:24] = cmd.data;
				tfhe_pkg::IP_OFS_DST + 5'd1: nx.dst[23:16] = cmd.data;
				tfhe_pkg::IP_OFS_DST + 5'd2: nx.dst[15:8] = cmd.data;
				tfhe_pkg::IP_OFS_DST + 5'd3: nx.dst[7:0] = cmd.data;
				default: ;
			endcase
		end
		// The TCP offset uses the IP header length as it stands after this byte.
		t = r - PW'(nx.ihb);
		t_ok = active && (r >= PW'(nx.ihb)) && (t < PW'(16));
		if (t_ok) begin
			case (t[3:0])
				tfhe_pkg::TCP_OFS_SPORT: nx.sport[15:8] = cmd.data;
				tfhe_pkg::TCP_OFS_SPORT + 4'd1: nx.sport[7:0] = cmd.data;
				tfhe_pkg::TCP_OFS_DPORT: nx.dport[15:8] = cmd.data;
				tfhe_pkg::TCP_OFS_DPORT + 4'd1: nx.dport[7:0] = cmd.data;
				tfhe_pkg::TCP_OFS_SEQ: nx.seq[31:24] = cmd.data;
				tfhe_pkg::TCP_OFS_SEQ + 4'd1: nx.seq[23:16] = cmd.data;
				tfhe_pkg::TCP_OFS_SEQ + 4'd2: nx.seq[15:8] = cmd.data;
				tfhe_pkg::TCP_OFS_SEQ + 4'd3: nx.seq[7:0] = cmd.data;
				tfhe_pkg::TCP_OFS_ACK: nx.ack[31:24] = cmd.data;
				tfhe_pkg::TCP_OFS_ACK + 4'd1: nx.ack[23:16] = cmd.data;
				tfhe_pkg::TCP_OFS_ACK + 4'd2: nx.ack[15:8] = cmd.data;
				tfhe_pkg::TCP_OFS_ACK + 4'd3: nx.ack[7:0] = cmd.data;
				tfhe_pkg::TCP_OFS_DOFF: nx.thb = {cmd.data[7:4], 2'b00};
				default: ;
			endcase
		end
		if (cmd.decide) begin
			if (cmd.ip_start != tfhe_pkg::IP_START_RAW) begin
				nx = '0;
			end
			nx.ip_start = cmd.ip_start;
		end
	end

	// ---- stage two: payload window and summary ----
	// The header registers already hold the state after the byte in stage two,
	// and stage one cannot move while stage two holds.
	always_comb begin
		diff = {1'b0, fr_q.tot} - 17'(fr_q.ihb) - 17'(fr_q.thb);
		len = diff[16] ? 16'd0 : diff[15:0];
		ipx = CW'(fr_q.ip_start);
		ihx = CW'(fr_q.ihb);
		thx = CW'(fr_q.thb);
		off = ipx + ihx + thx;
		pc = CW'(ent_s1.pos);
		tcp = (fr_q.ip_start != tfhe_pkg::IP_START_NONE) && (fr_q.proto == tfhe_pkg::PROTO_TCP);
		pay_hit = ent_s1.live && tcp
			&& (pc >= CW'(tfhe_pkg::ETH_HEAD_BYTES - 1))
			&& (pc >= ipx + CW'(tfhe_pkg::IP_OFS_PROTO))
			&& (pc >= ipx + ihx + CW'(tfhe_pkg::TCP_OFS_DOFF))
			&& (pc >= off) && (pc < off + CW'(len));

		res_pay = '0;
		res_pay.payload_value = ent_s1.data;

		res_sum = '0;
		res_sum.is_summary = 1'b1;
		res_sum.stamp_total_micros = ent_s1.stamp;
		if (fr_q.ip_start == tfhe_pkg::IP_START_NONE) begin
			res_sum.frame_status = tfhe_pkg::ST_NOT_IPV4;
		end else if (fr_q.proto != tfhe_pkg::PROTO_TCP) begin
			res_sum.frame_status = tfhe_pkg::ST_NOT_TCP;
		end else begin
			res_sum.frame_status = (len != 16'd0) ? tfhe_pkg::ST_TCP_DATA
				: tfhe_pkg::ST_TCP_EMPTY;
			res_sum.source_address = fr_q.src;
			res_sum.dest_address = fr_q.dst;
			res_sum.source_port = fr_q.sport;
			res_sum.dest_port = fr_q.dport;
			res_sum.sequence_number = fr_q.seq;
			res_sum.acknowledge_number = fr_q.ack;
			res_sum.payload_length = len;
		end
	end

	// A closing byte that is also payload yields two results, the payload item first and then the summary.
	assign need_pay = vld_s1 && pay_hit && !half_q;
	assign need_sum = vld_s1 && ent_s1.last;
	assign res_wr = (need_pay || need_sum) && !res_full;
	assign res = need_pay ? res_pay : res_sum;
	assign b_done = vld_s1 && (!(need_pay || need_sum) || (!res_full && !(need_pay && need_sum)));
	assign advance = !cmd_empty && (!vld_s1 || b_done);
	assign cmd_rd = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_q <= '0;
			vld_s1 <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (advance) begin
				fr_q <= nx;
				vld_s1 <= 1'b1;
			end else if (b_done) begin
				vld_s1 <= 1'b0;
			end
			if (b_done) begin
				half_q <= 1'b0;
			end else if (need_pay && need_sum && !res_full) begin
				half_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ent_s1 <= cmd;
		end
	end

endmodule

### hw/rtl/tfhe_res_fifo.sv
// ----------------------------------------------------------------------------
// tfhe_res_fifo: result queue at the output
// Holds finished payload and summary items until the consumer pops them.
// ----------------------------------------------------------------------------
module tfhe_res_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input tfhe_pkg::res_t wr_data,
	output logic full,
	input logic rd_en,
	output tfhe_pkg::res_t rd_data,
	output logic empty
);

	localparam int PTR_W = $clog2(tfhe_pkg::RES_DEPTH);
	localparam int CNT_W = $clog2(tfhe_pkg::RES_DEPTH + 1);

	tfhe_pkg::res_t mem_q [tfhe_pkg::RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = count_q == CNT_W'(tfhe_pkg::RES_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hw/rtl/tcp_frame_header_extractor_unit.sv
// ----------------------------------------------------------------------------
// tcp_frame_header_extractor_unit: Ethernet/IPv4/TCP header parser on bytes
// A result reaches the ports via the command queue, the back's stage register and the result queue.
// Throughput: one byte per cycle while full is low; a closing byte that is also
// payload holds the parser for its second result, since the result queue takes one per cycle.
// Reset (arst_n low) empties both queues and clears the frame position.
// ----------------------------------------------------------------------------
module tcp_frame_header_extractor_unit (
	input logic clk,
	input logic arst_n,
	// Byte intake: a transfer happens when push is high and full is low.
	input logic push,
	output logic full,
	input logic [7:0] frame_byte,
	input logic frame_end,
	input logic [31:0] stamp_seconds,
	input logic [19:0] stamp_micros,
	// Results: the oldest waiting item shows while empty is low.
	output logic empty,
	input logic pop,
	output logic [7:0] payload_value,
	output logic is_summary,
	output logic [1:0] frame_status,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [31:0] sequence_number,
	output logic [31:0] acknowledge_number,
	output logic [15:0] payload_length,
	output logic [51:0] stamp_total_micros
);

	// The front counts byte positions, samples the capture time on a frame's
	// first byte and classifies the link header on byte thirteen (or at an
	// earlier frame end). It turns every accepted byte into one command entry.
	logic cmd_wr;
	logic cmd_full;
	logic cmd_rd;
	logic cmd_empty;
	tfhe_pkg::cmd_t cmd_in;
	tfhe_pkg::cmd_t cmd_out;

	// The back captures header fields in its first stage and decides payload
	// bytes and the summary in its second. It writes into the result queue.
	logic res_wr;
	logic res_full;
	logic res_empty;
	tfhe_pkg::res_t res_in;
	tfhe_pkg::res_t res_out;

	tfhe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.stamp_seconds(stamp_seconds),
		.stamp_micros(stamp_micros),
		.cmd_wr(cmd_wr),
		.cmd(cmd_in),
		.cmd_full(cmd_full)
	);

	// The command queue lets the intake keep taking bytes while the back
	// waits on a full result queue.
	tfhe_cmd_fifo u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_wr),
		.wr_data(cmd_in),
		.full(cmd_full),
		.rd_en(cmd_rd),
		.rd_data(cmd_out),
		.empty(cmd_empty)
	);

	tfhe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cmd_empty),
		.cmd(cmd_out),
		.cmd_rd(cmd_rd),
		.res_full(res_full),
		.res_wr(res_wr),
		.res(res_in)
	);

	// Finished items wait here, so a stalled consumer does not stop the back
	// until the queue fills.
	tfhe_res_fifo u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_wr),
		.wr_data(res_in),
		.full(res_full),
		.rd_en(pop),
		.rd_data(res_out),
		.empty(res_empty)
	);

	assign empty = res_empty;

	// Payload items carry zero in every field but the payload byte; summary
	// items carry zero in the payload byte.
	assign payload_value = res_out.payload_value;
	assign is_summary = res_out.is_summary;
	assign frame_status = res_out.frame_status;
	assign source_address = res_out.source_address;
	assign dest_address = res_out.dest_address;
	assign source_port = res_out.source_port;
	assign dest_port = res_out.dest_port;
	assign sequence_number = res_out.sequence_number;
	assign acknowledge_number = res_out.acknowledge_number;
	assign payload_length = res_out.payload_length;
	assign stamp_total_micros = res_out.stamp_total_micros;

endmodule
